@@ hdl/frml_pkg.sv @@
// Shared types and constants of the frame rate meter and limiter.
// No dependencies; imported by the top level.
package frml_pkg;

  // payload field widths
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned FT_W      = 16;
  localparam int unsigned FPS_W     = 18;
  localparam int unsigned DELAY_W   = 10;
  localparam int unsigned MAXFPS_W  = 10;

  // stream word widths (padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;

  // arithmetic constants
  localparam int unsigned FPS_SCALE     = 256000;
  localparam int unsigned FPS_MAX       = 256000;
  localparam int unsigned MS_PER_SECOND = 1000;
  localparam int unsigned FT_MAX        = 65535;
  localparam int unsigned MAXFPS_RESET  = 60;

  // event kind carried in tuser
  typedef enum logic {
    KIND_BEGIN = 1'b0,
    KIND_END   = 1'b1
  } kind_e;

  // control sequencer, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

endpackage

@@ hdl/frml_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module frml_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 10,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/frml_serdiv.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// No dependencies; used by the top level for the rate and the frame budget.
module frml_serdiv #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one restoring step: shift in the next numerator bit, try to subtract
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], fits};
  end

  // step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

@@ hdl/frame_rate_meter_limiter.sv @@
// Top level of the frame rate meter and limiter.
// Depends on frml_pkg, frml_ram and frml_serdiv.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: now_ms; tuser: kind
//  m_*      out  m_tvalid/m_tready  tdata: frame_time_ms, fps_q8, delay_ms; tuser: average_zero
//  cfg      in   cfg_we_i           cfg_wdata_i: max_fps
//
// A begin item is taken in the idle state and needs no further work. An end item
// passes through accept, ring read, NUM_W steps of the bit-serial rate divider,
// a state that sees both dividers done, and output load; the budget divider runs
// alongside and is shorter.
// Reset needs no clearing pass: a ring entry is read only after it is written.
// A finished result waits in the output register; the next item is taken while
// it waits, and a following end item holds in its last state until it drains.
module frame_rate_meter_limiter #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [frml_pkg::IN_DATA_W-1:0]     s_tdata,  // [31:0] now_ms
  input  logic                               s_tuser,  // [0] kind
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [frml_pkg::OUT_DATA_W-1:0]    m_tdata,  // [15:0] frame_time_ms,
                                                       // [33:16] fps_q8,
                                                       // [43:34] delay_ms, [47:44] zero
  output logic                               m_tuser,  // [0] average_zero
  input  logic                               cfg_we_i,
  input  logic [frml_pkg::MAXFPS_W-1:0]      cfg_wdata_i
);

  import frml_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = $clog2(WINDOW * FT_MAX + 1);
  localparam int unsigned NUM_W = $clog2(FPS_SCALE * WINDOW + 1);
  localparam int unsigned BUD_W = DELAY_W;

  state_e              state_q, state_d;
  logic [MAXFPS_W-1:0] max_fps_q;
  logic [NOW_W-1:0]    start_q, prev_end_q;
  logic                seen_end_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [FPS_W-1:0]    fps_held_q;
  logic [FT_W-1:0]     ft_q;
  logic [NOW_W-1:0]    ft_diff, elapsed;
  logic                elapsed_big_q;
  logic [DELAY_W-1:0]  elapsed_lo_q;

  logic                in_fire, end_fire, out_free, out_load;
  logic [FT_W-1:0]     ring_rdata;
  logic                div_start;
  logic [NUM_W-1:0]    fps_num, fps_quo;
  logic                fps_busy, bud_busy;
  logic [MAXFPS_W-1:0] limit;
  logic [BUD_W-1:0]    budget;
  logic [FPS_W-1:0]    fps_res;
  logic [DELAY_W-1:0]  delay_res;
  logic                zero_res;

  assign s_tready = (state_q == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign end_fire = in_fire && (s_tuser == KIND_END);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state_q == ST_OUT) && out_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (end_fire) state_d = ST_READ;
      ST_READ: state_d = ST_DIV;
      ST_DIV:  if (!fps_busy && !bud_busy) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // time differences at accept, modulo 2^32
  assign ft_diff = s_tdata[NOW_W-1:0] - prev_end_q;
  assign elapsed = s_tdata[NOW_W-1:0] - start_q;

  // ring update: drop the oldest entry once the window is full
  always_comb begin
    if (cnt_q >= CNT_W'(WINDOW)) begin
      cnt_d = cnt_q;
      sum_d = sum_q - SUM_W'(ring_rdata) + SUM_W'(ft_q);
    end else begin
      cnt_d = cnt_q + 1'b1;
      sum_d = sum_q + SUM_W'(ft_q);
    end
  end

  assign div_start = (state_q == ST_READ);
  assign fps_num   = NUM_W'(FPS_SCALE * 32'(cnt_d));
  assign limit     = (max_fps_q == '0) ? MAXFPS_W'(1) : max_fps_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      max_fps_q  <= MAXFPS_W'(MAXFPS_RESET);
      start_q    <= '0;
      prev_end_q <= '0;
      seen_end_q <= 1'b0;
      pos_q      <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
      fps_held_q <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_fps_q <= cfg_wdata_i;
      end
      if (in_fire && (s_tuser == KIND_BEGIN)) begin
        start_q <= s_tdata[NOW_W-1:0];
      end
      if (end_fire) begin
        prev_end_q <= s_tdata[NOW_W-1:0];
        seen_end_q <= 1'b1;
      end
      if (state_q == ST_READ) begin
        cnt_q <= cnt_d;
        sum_q <= sum_d;
        pos_q <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
      end
      if (out_load && !zero_res) begin
        fps_held_q <= fps_res;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // per-item payload captured at accept
  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      if (!seen_end_q) begin
        ft_q <= '0;
      end else if (ft_diff > NOW_W'(FT_MAX)) begin
        ft_q <= FT_W'(FT_MAX);
      end else begin
        ft_q <= ft_diff[FT_W-1:0];
      end
      elapsed_big_q <= (elapsed[NOW_W-1:DELAY_W] != '0);
      elapsed_lo_q  <= elapsed[DELAY_W-1:0];
    end
  end

  // frame time ring
  frml_ram #(
    .WIDTH (FT_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_READ),
    .waddr_i (pos_q),
    .wdata_i (ft_q),
    .raddr_i (pos_q),
    .rdata_o (ring_rdata)
  );

  // averaged rate: 256000 * count / sum
  frml_serdiv #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_fps_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (fps_num),
    .den_i   (sum_d),
    .busy_o  (fps_busy),
    .quo_o   (fps_quo)
  );

  // frame budget: 1000 / limit
  frml_serdiv #(
    .NUM_W (BUD_W),
    .DEN_W (MAXFPS_W)
  ) u_bud_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (BUD_W'(MS_PER_SECOND)),
    .den_i   (limit),
    .busy_o  (bud_busy),
    .quo_o   (budget)
  );

  // result assembly: saturate rate, hold it on a zero sum, clamp the wait
  always_comb begin
    zero_res = (sum_q == '0);
    if (zero_res) begin
      fps_res = fps_held_q;
    end else if (fps_quo > NUM_W'(FPS_MAX)) begin
      fps_res = FPS_W'(FPS_MAX);
    end else begin
      fps_res = fps_quo[FPS_W-1:0];
    end
    if (!elapsed_big_q && (budget > elapsed_lo_q)) begin
      delay_res = budget - elapsed_lo_q;
    end else begin
      delay_res = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata <= {4'b0000, delay_res, fps_res, ft_q};
      m_tuser <= zero_res;
    end
  end

`ifndef SYNTH
  a_end_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_fire |=> (state_q == ST_READ))
    else $error("end item did not start the ring update");

  a_dividers_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (!fps_busy && !bud_busy))
    else $error("result taken while a divider is busy");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(WINDOW) || WINDOW == (1 << POS_W))
    else $error("ring position out of range");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW))
    else $error("frame count above window");
`endif

endmodule
